@@ rtl/lwed_pkg.sv @@
package lwed_pkg;

  localparam int CIPHER_W  = 32;
  localparam int PLAIN_W   = 17;
  localparam int PT_W      = 16;
  localparam int IN_DATA_W = 3 * CIPHER_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_CIPHER_MOD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PLAIN_MOD  = 2'd1;

  localparam logic [CIPHER_W-1:0] CIPHER_MOD_RST = 32'd4096;
  localparam logic [PLAIN_W-1:0]  PLAIN_MOD_RST  = 17'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an accepted input item
    logic red_step;  // one bit of the operand reductions mod q
    logic red_last;  // final reduction bit: commit the residues
    logic mul_step;  // one bit of the modular multiply
    logic acc_add;   // add the product into the running sum
    logic sub;       // form d = b - sum mod q and set up scaling
    logic scl_step;  // one bit of the scaling by t / q
    logic round;     // round-half-up correction
    logic emit;      // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_reduce;
    logic last;
    logic out_full;
  } dp_sts_t;

endpackage

@@ rtl/lwed_modstep.sv @@
// One modular step: r_out = (dbl ? 2r : r) + (add_en ? addend : 0) mod q,
// with r and addend below q, so the sum stays below 3q. k is the number of
// times q was taken off.
module lwed_modstep #(
  parameter int W = 32
) (
  input  logic [W-1:0] r_in,
  input  logic [W-1:0] addend,
  input  logic [W-1:0] q,
  input  logic         dbl,
  input  logic         add_en,
  output logic [W-1:0] r_out,
  output logic [1:0]   k
);

  logic [W+1:0] base;
  logic [W+1:0] add_term;
  logic [W+1:0] x;
  logic [W+1:0] q1;
  logic [W+1:0] q2;
  logic [W+1:0] x_m1;
  logic [W+1:0] x_m2;

  always_comb begin
    base     = dbl ? {1'b0, r_in, 1'b0} : {2'b00, r_in};
    add_term = add_en ? {2'b00, addend} : '0;
    x        = base + add_term;
    q1       = {2'b00, q};
    q2       = {1'b0, q, 1'b0};
    x_m1     = x - q1;
    x_m2     = x - q2;
    if (x >= q2) begin
      r_out = x_m2[W-1:0];
      k     = 2'd2;
    end else if (x >= q1) begin
      r_out = x_m1[W-1:0];
      k     = 2'd1;
    end else begin
      r_out = x[W-1:0];
      k     = 2'd0;
    end
  end

endmodule

@@ rtl/lwed_dp.sv @@
module lwed_dp
  import lwed_pkg::*;
#(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [W-1:0]       q,
  input  logic [PLAIN_W-1:0] t,
  input  logic [W-1:0]       in_a,
  input  logic [W-1:0]       in_s,
  input  logic [W-1:0]       in_b,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PT_W-1:0]    out_data
);

  logic [W-1:0]       a_r, s_r, b_r, acc_r, r_r;
  logic [W-1:0]       a_rem_r, acc_rem_r, b_rem_r;
  logic               last_r;
  logic [PLAIN_W-1:0] t_r, quo_r;
  logic               out_valid_r;
  logic [PT_W-1:0]    out_data_r;

  logic [W-1:0] a_rem_nxt, acc_rem_nxt, b_rem_nxt;
  logic [W-1:0] step_r_in, step_addend, step_r_out;
  logic         step_dbl, step_en;
  logic [1:0]   step_k;
  logic [W:0]   diff;
  logic [W-1:0] d_val;
  logic [PLAIN_W-1:0] pt_val;

  // Shift one operand bit into a residue and fold it back below q.
  function automatic logic [W-1:0] red_bit(input logic [W-1:0] rem, input logic bit_in,
                                           input logic [W-1:0] qv);
    logic [W:0] x;
    x = {rem, bit_in};
    if (x >= {1'b0, qv}) begin
      x = x - {1'b0, qv};
    end
    return x[W-1:0];
  endfunction

  assign a_rem_nxt   = red_bit(a_rem_r, a_r[W-1], q);
  assign acc_rem_nxt = red_bit(acc_rem_r, acc_r[W-1], q);
  assign b_rem_nxt   = red_bit(b_rem_r, b_r[W-1], q);

  // The step unit is shared by the multiply, the accumulate, the scaling
  // and the rounding; the addend register holds a during the multiply and
  // d during the scaling.
  always_comb begin
    step_r_in   = cmd.acc_add ? acc_r : r_r;
    step_addend = cmd.acc_add ? r_r : a_r;
    step_dbl    = !cmd.acc_add;
    step_en     = cmd.acc_add | (cmd.mul_step & s_r[W-1]) |
                  (cmd.scl_step & t_r[PLAIN_W-1]);
  end

  lwed_modstep #(.W(W)) u_step (
    .r_in   (step_r_in),
    .addend (step_addend),
    .q      (q),
    .dbl    (step_dbl),
    .add_en (step_en),
    .r_out  (step_r_out),
    .k      (step_k)
  );

  always_comb begin
    diff  = {1'b0, b_r} - {1'b0, acc_r};
    d_val = diff[W] ? (diff[W-1:0] + q) : diff[W-1:0];
    pt_val = (quo_r == t) ? '0 : quo_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r       <= in_a;
      s_r       <= in_s;
      b_r       <= in_b;
      last_r    <= in_last;
      r_r       <= '0;
      a_rem_r   <= '0;
      acc_rem_r <= '0;
      b_rem_r   <= '0;
    end
    if (cmd.red_step) begin
      if (cmd.red_last) begin
        a_r <= a_rem_nxt;
        b_r <= b_rem_nxt;
      end else begin
        a_r <= a_r << 1;
        b_r <= b_r << 1;
      end
      a_rem_r   <= a_rem_nxt;
      acc_rem_r <= acc_rem_nxt;
      b_rem_r   <= b_rem_nxt;
    end
    if (cmd.mul_step) begin
      r_r <= step_r_out;
      s_r <= s_r << 1;
    end
    if (cmd.sub) begin
      a_r   <= d_val;
      r_r   <= '0;
      quo_r <= '0;
      t_r   <= t;
    end
    if (cmd.scl_step) begin
      r_r   <= step_r_out;
      quo_r <= {quo_r[PLAIN_W-2:0], 1'b0} + PLAIN_W'(step_k);
      t_r   <= t_r << 1;
    end
    if (cmd.round) begin
      quo_r <= quo_r + PLAIN_W'(step_k);
    end
    if (cmd.emit) begin
      out_data_r <= pt_val[PT_W-1:0];
    end
  end

  // The running sum is architectural state and resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.red_step) begin
      acc_r <= cmd.red_last ? acc_rem_nxt : (acc_r << 1);
    end else if (cmd.acc_add) begin
      acc_r <= step_r_out;
    end else if (cmd.sub) begin
      acc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.need_reduce = (a_r >= q) || (acc_r >= q) || (last_r && (b_r >= q));
    sts.last        = last_r;
    sts.out_full    = out_valid_r && !out_ready;
  end

  a_step_shared: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_step, cmd.acc_add, cmd.scl_step, cmd.round, cmd.red_step, cmd.sub}))
    else $error("more than one datapath operation in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transfer");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ rtl/lwed_ctrl.sv @@
module lwed_ctrl
  import lwed_pkg::*;
#(
  parameter int W = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam int STEPS = (W > PLAIN_W) ? W : PLAIN_W;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_MUL,
    S_ACCUM,
    S_SUB,
    S_SCALE,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             cnt_zero;

  assign in_ready = (state_r == S_IDLE);
  assign cnt_zero = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt_r   <= CNT_W'(W - 1);
          state_r <= sts.need_reduce ? S_REDUCE : S_MUL;
        end
        S_REDUCE: begin
          if (cnt_zero) begin
            cnt_r   <= CNT_W'(W - 1);
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MUL: begin
          if (cnt_zero) begin
            state_r <= S_ACCUM;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_ACCUM: begin
          state_r <= sts.last ? S_SUB : S_IDLE;
        end
        S_SUB: begin
          cnt_r   <= CNT_W'(PLAIN_W - 1);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          if (cnt_zero) begin
            state_r <= S_ROUND;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_ROUND: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!sts.out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.red_step = (state_r == S_REDUCE);
    cmd.red_last = (state_r == S_REDUCE) && cnt_zero;
    cmd.mul_step = (state_r == S_MUL);
    cmd.acc_add  = (state_r == S_ACCUM);
    cmd.sub      = (state_r == S_SUB);
    cmd.scl_step = (state_r == S_SCALE);
    cmd.round    = (state_r == S_ROUND);
    cmd.emit     = (state_r == S_EMIT) && !sts.out_full;
  end

endmodule

@@ rtl/lwe_decrypt.sv @@
// LWE decryption, one ciphertext element and key element per input transfer;
// a transfer with tlast also carries the body b and yields one plaintext
// transfer. An item without tlast is taken and then held until the
// bit-serial modular multiply, one bit per cycle through the shared modular
// step unit, and the accumulate are done; only then is the next transfer
// taken. If the element, the held sum or (on a last item) the body is at
// or above q, a bit-serial reduction runs first. A last item then goes on
// to the subtraction, 17 scaling steps through the same unit, the rounding
// step and the load of the output register, which waits while an earlier
// result has not been taken. Configuration writes are taken in any cycle,
// but belong only where no item is in flight.
module lwe_decrypt
  import lwed_pkg::*;
#(
  parameter int MOD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // cipher_elem, key_elem, body
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PT_W-1:0]       out_tdata, // plaintext
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W  = MOD_WIDTH;
  localparam int EW = (W > CIPHER_W) ? W : CIPHER_W;

  logic [CIPHER_W-1:0] q_cfg_r;
  logic [PLAIN_W-1:0]  t_cfg_r;

  logic [EW-1:0] q_ext, a_ext, s_ext, b_ext;
  logic [W-1:0]  q_eff;
  dp_cmd_t       cmd;
  dp_sts_t       sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cfg_r <= CIPHER_MOD_RST;
      t_cfg_r <= PLAIN_MOD_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_CIPHER_MOD: q_cfg_r <= cfg_data[CIPHER_W-1:0];
        REG_PLAIN_MOD:  t_cfg_r <= cfg_data[PLAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Operands live at MOD_WIDTH bits; a modulus of zero acts as one.
  always_comb begin
    q_ext = EW'(q_cfg_r);
    a_ext = EW'(in_tdata[CIPHER_W-1:0]);
    s_ext = EW'(in_tdata[2*CIPHER_W-1:CIPHER_W]);
    b_ext = EW'(in_tdata[3*CIPHER_W-1:2*CIPHER_W]);
    q_eff = (q_ext[W-1:0] == '0) ? {{(W-1){1'b0}}, 1'b1} : q_ext[W-1:0];
  end

  lwed_ctrl #(.W(W)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lwed_dp #(.W(W)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .q         (q_eff),
    .t         (t_cfg_r),
    .in_a      (a_ext[W-1:0]),
    .in_s      (s_ext[W-1:0]),
    .in_b      (b_ext[W-1:0]),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
